@@ rtl/glpf_pkg.sv @@
`timescale 1ns / 1ps
// glpf_pkg: shared constants and types of the grid local peak finder.
// No dependencies; used by the interfaces, the cells, the judge and the top level.

package glpf_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 6;

    // result field widths
    localparam int ROW_OUT_W  = 10;
    localparam int COL_OUT_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS = 2'd0,
        CFG_FRAME_COLS = 2'd1
    } cfg_reg_t;

    // edit applied by a ring cell to the neighbor data it takes in
    typedef struct packed {
        logic wr_pix;
        logic bank;
        logic wr_flag;
        logic flag_val;
    } cell_edit_t;

    localparam cell_edit_t EDIT_NONE = '{wr_pix: 1'b0, bank: 1'b0,
                                         wr_flag: 1'b0, flag_val: 1'b0};

    // which neighbors exist around the pixels being judged
    typedef struct packed {
        logic has_up;
        logic has_up2;
        logic has_left;
        logic has_left2;
        logic has_right;
    } judge_ctx_t;

    typedef struct packed {
        logic above_ok;
        logic left_ok;
        logic cur_ok;
    } judge_t;

endpackage

@@ rtl/glpf_ifs.sv @@
`timescale 1ns / 1ps
// glpf_pixel_if and glpf_peak_if: valid/ready channels of the peak finder.
// Depends on glpf_pkg for the result field widths.

interface glpf_pixel_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface glpf_peak_if;
    logic                              valid;
    logic                              ready;
    logic [glpf_pkg::ROW_OUT_W-1:0]    peak_row;
    logic [glpf_pkg::COL_OUT_W-1:0]    peak_col;
    logic                              run_last;

    modport source (output valid, output peak_row, output peak_col, output run_last,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input run_last,
                    output ready);
endinterface

@@ rtl/grid_local_peak_finder.sv @@
`timescale 1ns / 1ps
// grid_local_peak_finder: 2-D 4-neighbor local-maximum detector, top level.
// Depends on glpf_pkg, glpf_ifs (channel interfaces), glpf_cell and glpf_judge.
//
//   port        | kind                  | direction | transaction payload
//   ------------+-----------------------+-----------+-----------------------------------
//   pixels      | valid/ready           | in        | pixel (signed, PIXEL_BITS)
//   peaks       | valid/ready           | out       | peak_row[9:0] peak_col[4:0] run_last
//   cfg_*       | write enable, no wait | in        | cfg_index -> frame_rows/frame_cols
//
// Flow: one pixel per cycle inside a row while no peak waits for a busy output register.
// At a row end the column ring rotates back to column 0. At the frame's final pixel the
// ring realigns to column 0, then scans the bottom-row flags of all MAX_COLS columns,
// then flushes the held result.
// Reset: async active low; counters, flags, FSM and config go to their reset values.
// The line store pixels have no reset and need no clearing pass.
// Stalls: a single output register plus one hold slot. pixels.ready is a registered
// state decode; a peak that finds the output register busy parks in the hold slot and
// the input pauses in the flush state until peaks.ready frees the register. In the
// flag scan a set flag waits while both the hold slot and the output register are full.

module grid_local_peak_finder #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    glpf_pixel_if.sink                          pixels,
    glpf_peak_if.source                         peaks,
    input  logic                                cfg_we,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROWS_CFG_W = glpf_pkg::ROWS_CFG_W;
    localparam int COLS_CFG_W = glpf_pkg::COLS_CFG_W;
    localparam int ROW_OUT_W  = glpf_pkg::ROW_OUT_W;
    localparam int COL_OUT_W  = glpf_pkg::COL_OUT_W;
    localparam int TAIL       = MAX_COLS - 1;   // ring slot holding column c-1
    localparam int PREV2      = MAX_COLS - 2;   // ring slot holding column c-2

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN_ROW,
        ST_ALIGN_FRAME,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers, clamped into range at write time
    // ------------------------------------------------------------------
    logic [ROWS_CFG_W-1:0] frame_rows_reg;
    logic [ROWS_CFG_W-1:0] frame_rows_next;
    logic [COLS_CFG_W-1:0] frame_cols_reg;
    logic [COLS_CFG_W-1:0] frame_cols_next;
    logic [ROWS_CFG_W-1:0] rows_wr;
    logic [COLS_CFG_W-1:0] cols_wr;
    logic [ROWS_CFG_W-1:0] rows_clamped;
    logic [COLS_CFG_W-1:0] cols_clamped;

    assign rows_wr = cfg_data[ROWS_CFG_W-1:0];
    assign cols_wr = cfg_data[COLS_CFG_W-1:0];

    assign rows_clamped = (rows_wr == '0) ? ROWS_CFG_W'(1) :
                          (rows_wr > ROWS_CFG_W'(MAX_ROWS)) ? ROWS_CFG_W'(MAX_ROWS) : rows_wr;
    assign cols_clamped = (cols_wr == '0) ? COLS_CFG_W'(1) :
                          (cols_wr > COLS_CFG_W'(MAX_COLS)) ? COLS_CFG_W'(MAX_COLS) : cols_wr;

    always_comb
    begin
        frame_rows_next = frame_rows_reg;
        frame_cols_next = frame_cols_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                glpf_pkg::CFG_FRAME_ROWS: frame_rows_next = rows_clamped;
                glpf_pkg::CFG_FRAME_COLS: frame_cols_next = cols_clamped;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_CFG_W'(1);
            frame_cols_reg <= COLS_CFG_W'(1);
        end
        else
        begin
            frame_rows_reg <= frame_rows_next;
            frame_cols_reg <= frame_cols_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                state_reg;
    state_t                state_next;
    logic [ROW_W-1:0]      row_reg;        // row of the next pixel
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      head_reg;       // column held by ring slot 0
    logic [COL_W-1:0]      head_next;
    logic [ROW_W-1:0]      burst_row_reg;
    logic [ROW_W-1:0]      burst_row_next;
    logic                  hold_valid_reg; // result waiting for its run_last decision
    logic                  hold_valid_next;
    logic [ROW_W-1:0]      hold_row_reg;
    logic [ROW_W-1:0]      hold_row_next;
    logic [COL_W-1:0]      hold_col_reg;
    logic [COL_W-1:0]      hold_col_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ROW_OUT_W-1:0]  out_row_reg;
    logic [ROW_OUT_W-1:0]  out_row_next;
    logic [COL_OUT_W-1:0]  out_col_reg;
    logic [COL_OUT_W-1:0]  out_col_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    // ------------------------------------------------------------------
    // Column ring: slot j holds column (head + j) mod MAX_COLS, both row banks
    // and the bottom-row peak flag. Every rotation moves slot j+1 into slot j.
    // ------------------------------------------------------------------
    logic signed [PIXEL_BITS-1:0] cell_b0 [MAX_COLS];
    logic signed [PIXEL_BITS-1:0] cell_b1 [MAX_COLS];
    logic [MAX_COLS-1:0]          cell_flag;
    logic                         ring_shift;
    glpf_pkg::cell_edit_t         edit_tail;   // applied to the head as it wraps to the tail
    glpf_pkg::cell_edit_t         edit_prev;   // applied to column c-1 as it moves up
    logic signed [PIXEL_BITS-1:0] pix;

    assign pix = pixels.pixel;

    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_ring
        localparam int NXT = (j + 1) % MAX_COLS;
        glpf_pkg::cell_edit_t edit_j;

        if (j == TAIL)
        begin : g_tail
            assign edit_j = edit_tail;
        end
        else if (j == PREV2)
        begin : g_prev
            assign edit_j = edit_prev;
        end
        else
        begin : g_plain
            assign edit_j = glpf_pkg::EDIT_NONE;
        end

        glpf_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ring_shift),
            .edit     (edit_j),
            .wr_data  (pix),
            .nbr_b0   (cell_b0[NXT]),
            .nbr_b1   (cell_b1[NXT]),
            .nbr_flag (cell_flag[NXT]),
            .b0       (cell_b0[j]),
            .b1       (cell_b1[j]),
            .flag     (cell_flag[j])
        );
    end

    // ------------------------------------------------------------------
    // Neighbor window and verdicts. Bank row_reg[0] holds row r (and r-2),
    // the other bank holds row r-1.
    // ------------------------------------------------------------------
    logic                         cur_bank;
    logic                         row_end;
    logic                         last_row;
    logic                         head_wrap;
    logic [COL_W-1:0]             head_inc;
    logic                         out_free;
    logic signed [PIXEL_BITS-1:0] w_up;
    logic signed [PIXEL_BITS-1:0] w_up2;
    logic signed [PIXEL_BITS-1:0] w_up_left;
    logic signed [PIXEL_BITS-1:0] w_up_right;
    logic signed [PIXEL_BITS-1:0] w_left;
    logic signed [PIXEL_BITS-1:0] w_left2;
    glpf_pkg::judge_ctx_t         ctx;
    glpf_pkg::judge_t             verdict;

    assign cur_bank   = row_reg[0];
    assign w_up       = cur_bank ? cell_b0[0]     : cell_b1[0];
    assign w_up2      = cur_bank ? cell_b1[0]     : cell_b0[0];
    assign w_up_right = cur_bank ? cell_b0[1]     : cell_b1[1];
    assign w_up_left  = cur_bank ? cell_b0[TAIL]  : cell_b1[TAIL];
    assign w_left     = cur_bank ? cell_b1[TAIL]  : cell_b0[TAIL];
    assign w_left2    = cur_bank ? cell_b1[PREV2] : cell_b0[PREV2];

    assign row_end   = (COLS_CFG_W'(head_reg) + COLS_CFG_W'(1)) >= frame_cols_reg;
    assign last_row  = (ROWS_CFG_W'(row_reg) + ROWS_CFG_W'(1)) >= frame_rows_reg;
    assign head_wrap = (head_reg == COL_W'(TAIL));
    assign head_inc  = head_wrap ? '0 : head_reg + COL_W'(1);
    assign out_free  = !out_valid_reg || peaks.ready;

    assign ctx.has_up    = (row_reg != '0);
    assign ctx.has_up2   = (row_reg > ROW_W'(1));
    assign ctx.has_left  = (head_reg != '0);
    assign ctx.has_left2 = (head_reg > COL_W'(1));
    assign ctx.has_right = !row_end;

    glpf_judge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_judge (
        .ctx      (ctx),
        .pix      (pix),
        .up       (w_up),
        .up2      (w_up2),
        .up_left  (w_up_left),
        .up_right (w_up_right),
        .left     (w_left),
        .left2    (w_left2),
        .verdict  (verdict)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        head_next       = head_reg;
        burst_row_next  = burst_row_reg;
        hold_valid_next = hold_valid_reg;
        hold_row_next   = hold_row_reg;
        hold_col_next   = hold_col_reg;
        out_valid_next  = out_valid_reg && !peaks.ready;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_last_next   = out_last_reg;
        ring_shift      = 1'b0;
        edit_tail       = glpf_pkg::EDIT_NONE;
        edit_prev       = glpf_pkg::EDIT_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixels.valid)
                begin
                    ring_shift         = 1'b1;
                    head_next          = head_inc;
                    // store the pixel, update bottom-row flags of columns c-1 and c
                    edit_tail.wr_pix   = 1'b1;
                    edit_tail.bank     = cur_bank;
                    edit_tail.wr_flag  = last_row && row_end;
                    edit_tail.flag_val = verdict.cur_ok;
                    edit_prev.wr_flag  = last_row && ctx.has_left;
                    edit_prev.flag_val = verdict.left_ok;

                    if (row_end && last_row)
                    begin
                        // frame end: above result waits in hold, burst follows
                        hold_valid_next = verdict.above_ok;
                        hold_row_next   = row_reg - ROW_W'(1);
                        hold_col_next   = head_reg;
                        burst_row_next  = row_reg;
                        row_next        = '0;
                        state_next      = head_wrap ? ST_SCAN : ST_ALIGN_FRAME;
                    end
                    else
                    begin
                        if (verdict.above_ok && out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = ROW_OUT_W'(row_reg - ROW_W'(1));
                            out_col_next   = COL_OUT_W'(head_reg);
                            out_last_next  = 1'b1;
                        end
                        else if (verdict.above_ok)
                        begin
                            hold_valid_next = 1'b1;
                            hold_row_next   = row_reg - ROW_W'(1);
                            hold_col_next   = head_reg;
                        end

                        if (row_end)
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end

                        if (row_end && !head_wrap)
                        begin
                            state_next = ST_ALIGN_ROW;
                        end
                        else if (verdict.above_ok && !out_free)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_ALIGN_ROW:
            begin
                ring_shift = 1'b1;
                head_next  = head_inc;
                if (head_wrap)
                begin
                    state_next = hold_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_ALIGN_FRAME:
            begin
                ring_shift = 1'b1;
                head_next  = head_inc;
                if (head_wrap)
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // a set flag with a pending hold needs the output register free
                if (!(cell_flag[0] && hold_valid_reg && !out_free))
                begin
                    ring_shift         = 1'b1;
                    head_next          = head_inc;
                    edit_tail.wr_flag  = 1'b1;
                    edit_tail.flag_val = 1'b0;
                    if (cell_flag[0])
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = ROW_OUT_W'(hold_row_reg);
                            out_col_next   = COL_OUT_W'(hold_col_reg);
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_row_next   = burst_row_reg;
                        hold_col_next   = head_reg;
                    end
                    if (head_wrap)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = ROW_OUT_W'(hold_row_reg);
                    out_col_next    = COL_OUT_W'(hold_col_reg);
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            head_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            burst_row_reg  <= '0;
            hold_row_reg   <= '0;
            hold_col_reg   <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            head_reg       <= head_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            burst_row_reg  <= burst_row_next;
            hold_row_reg   <= hold_row_next;
            hold_col_reg   <= hold_col_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign pixels.ready   = (state_reg == ST_IDLE);
    assign peaks.valid    = out_valid_reg;
    assign peaks.peak_row = out_row_reg;
    assign peaks.peak_col = out_col_reg;
    assign peaks.run_last = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("hold slot occupied while taking pixels");

    a_align_not_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN_ROW || state_reg == ST_ALIGN_FRAME) |-> (head_reg != '0))
        else $error("ring realignment ran past column 0");

    a_scan_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_SCAN && state_reg == ST_FLUSH) |-> (cell_flag == '0))
        else $error("bottom-row flags left set after the burst scan");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(MAX_ROWS - 1))
        else $error("row counter beyond the largest frame");

endmodule

@@ rtl/glpf_cell.sv @@
`timescale 1ns / 1ps
// glpf_cell: one column slot of the rotating line-store ring (two row banks + bottom flag).
// Depends on glpf_pkg (cell_edit_t).

module glpf_cell #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  glpf_pkg::cell_edit_t         edit,
    input  logic signed [PIXEL_BITS-1:0] wr_data,
    input  logic signed [PIXEL_BITS-1:0] nbr_b0,
    input  logic signed [PIXEL_BITS-1:0] nbr_b1,
    input  logic                         nbr_flag,
    output logic signed [PIXEL_BITS-1:0] b0,
    output logic signed [PIXEL_BITS-1:0] b1,
    output logic                         flag
);

    logic signed [PIXEL_BITS-1:0] b0_reg;
    logic signed [PIXEL_BITS-1:0] b0_next;
    logic signed [PIXEL_BITS-1:0] b1_reg;
    logic signed [PIXEL_BITS-1:0] b1_next;
    logic                         flag_reg;
    logic                         flag_next;

    always_comb
    begin
        b0_next   = b0_reg;
        b1_next   = b1_reg;
        flag_next = flag_reg;
        if (shift)
        begin
            b0_next   = nbr_b0;
            b1_next   = nbr_b1;
            flag_next = nbr_flag;
            if (edit.wr_pix && !edit.bank)
            begin
                b0_next = wr_data;
            end
            if (edit.wr_pix && edit.bank)
            begin
                b1_next = wr_data;
            end
            if (edit.wr_flag)
            begin
                flag_next = edit.flag_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    // pixel banks: undefined until written
    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
    end

    assign b0   = b0_reg;
    assign b1   = b1_reg;
    assign flag = flag_reg;

endmodule

@@ rtl/glpf_judge.sv @@
`timescale 1ns / 1ps
// glpf_judge: 4-neighbor comparisons for the pixel above, the bottom-row left
// neighbor and the current bottom-row pixel. Depends on glpf_pkg.

module glpf_judge #(
    parameter int PIXEL_BITS = 16
) (
    input  glpf_pkg::judge_ctx_t         ctx,
    input  logic signed [PIXEL_BITS-1:0] pix,
    input  logic signed [PIXEL_BITS-1:0] up,
    input  logic signed [PIXEL_BITS-1:0] up2,
    input  logic signed [PIXEL_BITS-1:0] up_left,
    input  logic signed [PIXEL_BITS-1:0] up_right,
    input  logic signed [PIXEL_BITS-1:0] left,
    input  logic signed [PIXEL_BITS-1:0] left2,
    output glpf_pkg::judge_t             verdict
);

    always_comb
    begin
        // pixel above the incoming one now has all its neighbors
        verdict.above_ok = ctx.has_up && (up >= pix)
                           && !(ctx.has_up2   && (up < up2))
                           && !(ctx.has_left  && (up < up_left))
                           && !(ctx.has_right && (up < up_right));
        // bottom row, left neighbor: its right neighbor is the incoming pixel
        verdict.left_ok  = (left >= pix)
                           && !(ctx.has_up    && (left < up_left))
                           && !(ctx.has_left2 && (left < left2));
        // bottom row, last column: incoming pixel has no right neighbor
        verdict.cur_ok   = !(ctx.has_up   && (pix < up))
                           && !(ctx.has_left && (pix < left));
    end

endmodule
